[rtl/vruntime_run_queue_scheduler_assert.svh]
// Assertion macros for the run queue scheduler.
`ifndef VRUNTIME_RUN_QUEUE_SCHEDULER_ASSERT_SVH
`define VRUNTIME_RUN_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle check, off during reset.
`define VRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle implication, off during reset.
`define VRQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/vrq_pkg.sv]
// Shared types and constants of the run queue scheduler.
package vrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned RT_W    = 63;
  localparam int unsigned LVL_W   = 2;
  localparam int unsigned BASE_W  = 8;
  localparam int unsigned SLICE_W = 10;
  localparam int unsigned RUN_W   = 5;
  localparam int unsigned FRONT_DEPTH = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 10'd4;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd4;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SCHED  = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_IDLE_ID  = 2'd0;
  localparam logic [1:0] REG_IDLE_RT  = 2'd1;
  localparam logic [1:0] REG_IDLE_LVL = 2'd2;
  localparam logic [1:0] REG_BASE     = 2'd3;

  typedef enum logic [1:0] {
    K_INSERT = 2'd0,
    K_SCHED  = 2'd1,
    K_TICK   = 2'd2,
    K_NOP    = 2'd3
  } vrq_kind_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [ID_W-1:0]  task_id;
    logic [RT_W-1:0]  runtime;
    logic [LVL_W-1:0] level;
    logic             is_running;
  } vrq_in_t;

  typedef struct packed {
    logic [ID_W-1:0]    next_id;
    logic               switched;
    logic [SLICE_W-1:0] slice_left;
    logic [RUN_W-1:0]   runnable;
    logic               overflow;
  } vrq_out_t;

  typedef struct packed {
    vrq_kind_e        kind;
    logic [ID_W-1:0]  task_id;
    logic [RT_W-1:0]  runtime;
    logic [LVL_W-1:0] level;
    logic             is_running;
  } vrq_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   idle_id;
    logic [RT_W-1:0]   idle_rt;
    logic [LVL_W-1:0]  idle_lvl;
    logic [BASE_W-1:0] base;
  } vrq_cfg_t;

endpackage

[rtl/vrq_front.sv]
// Input side: decodes words and holds them in a short queue for the back end.
module vrq_front import vrq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  vrq_in_t   word_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output vrq_item_t item_o
);

  localparam int unsigned PW = $clog2(FRONT_DEPTH);
  localparam int unsigned CW = $clog2(FRONT_DEPTH + 1);

  vrq_item_t       buf_q [FRONT_DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            wr_en, rd_en;
  vrq_item_t       dec;

  always_comb begin
    unique case (word_i.action)
      ACT_INSERT: dec.kind = K_INSERT;
      ACT_SCHED:  dec.kind = K_SCHED;
      ACT_TICK:   dec.kind = K_TICK;
      default:    dec.kind = K_NOP;
    endcase
    dec.task_id    = word_i.task_id;
    dec.runtime    = word_i.runtime;
    dec.level      = word_i.level;
    dec.is_running = word_i.is_running;
  end

  assign full_o       = (cnt_q == CW'(FRONT_DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = buf_q[rd_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_valid_o && item_ready_i;

  always_comb begin
    wr_d  = wr_en ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = rd_en ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (wr_en && !rd_en) cnt_d = CW'(cnt_q + 1'b1);
    else if (!wr_en && rd_en) cnt_d = CW'(cnt_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_q] <= dec;
  end

endmodule

[rtl/vrq_div.sv]
// Restoring divider, one quotient bit per cycle, for the slice reload.
module vrq_div import vrq_pkg::*; #(
  parameter int unsigned DIV_W = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [BASE_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [BASE_W-1:0] quot_o
);

  localparam int unsigned SW = $clog2(BASE_W + 1);

  logic [SW-1:0]     step_q, step_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [BASE_W-1:0] dvd_q, dvd_d;
  logic [DIV_W-1:0]  dvs_q, dvs_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DIV_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[BASE_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = SW'(BASE_W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // quotient bits shift in where the dividend bits leave
      rem_d  = fits ? DIV_W'(trial - {1'b0, dvs_q}) : DIV_W'(trial);
      dvd_d  = {dvd_q[BASE_W-2:0], fits};
      step_d = SW'(step_q - 1'b1);
      if (step_q == SW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

[rtl/vrq_back.sv]
// Execution side: sorted run queue, schedule decision, slice bookkeeping.
module vrq_back import vrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  vrq_cfg_t  cfg_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  input  vrq_item_t item_i,
  input  logic      res_ready_i,
  output logic      res_load_o,
  output vrq_out_t  res_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count_o
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW = QW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_RLD  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [ID_W-1:0]  ent_id_q  [QUEUE_DEPTH];
  logic [RT_W-1:0]  ent_rt_q  [QUEUE_DEPTH];
  logic [LVL_W-1:0] ent_lvl_q [QUEUE_DEPTH];

  logic [2:0]         st_q, st_d;
  logic [QW-1:0]      cnt_q, cnt_d;
  logic [SLICE_W-1:0] slice_q, slice_d;
  logic               ins_pend_q, ins_pend_d;
  logic [ID_W-1:0]    ins_id_q, ins_id_d;
  logic [RT_W-1:0]    ins_rt_q, ins_rt_d;
  logic [LVL_W-1:0]   ins_lvl_q, ins_lvl_d;
  logic [LVL_W-1:0]   c_lvl_q, c_lvl_d;
  logic               sched_q, sched_d;
  logic [ID_W-1:0]    next_q, next_d;
  logic               sw_q, sw_d;
  logic               ovf_q, ovf_d;

  logic               take, do_pop, do_ins, q_full;
  logic [ID_W-1:0]    c_id;
  logic [RT_W-1:0]    c_rt;
  logic [LVL_W-1:0]   c_lvl;
  logic [QUEUE_DEPTH-1:0] lt;
  logic               div_start, div_done;
  logic [BASE_W-1:0]  quot;
  logic [SLICE_W-1:0] reload;
  logic [31:0]        run_ext;

  assign item_ready_o = (st_q == S_IDLE);
  assign take   = item_valid_i && item_ready_o;
  assign q_full = (cnt_q == QW'(QUEUE_DEPTH));
  assign do_pop = take && (item_i.kind == K_SCHED) && (cnt_q != '0);
  assign do_ins = (st_q == S_INS) && ins_pend_q && (ins_id_q != cfg_i.idle_id) && !q_full;

  always_comb begin
    if (cnt_q == '0) begin
      c_id  = cfg_i.idle_id;
      c_rt  = cfg_i.idle_rt;
      c_lvl = cfg_i.idle_lvl;
    end else begin
      c_id  = ent_id_q[0];
      c_rt  = ent_rt_q[0];
      c_lvl = ent_lvl_q[0];
    end
  end

  // thermometer of entries that stay ahead of the new task
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      lt[k] = (QW'(k) < cnt_q) && (ent_rt_q[k] < ins_rt_q);
    end
  end

  assign reload = (c_lvl_q >= 2'd2) ? SLICE_W'({2'b00, quot} + {1'b0, quot, 1'b0})
                                    : SLICE_W'(quot);
  assign div_start = (st_q == S_RLD) && (slice_q == '0);

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    slice_d    = slice_q;
    ins_pend_d = ins_pend_q;
    ins_id_d   = ins_id_q;
    ins_rt_d   = ins_rt_q;
    ins_lvl_d  = ins_lvl_q;
    c_lvl_d    = c_lvl_q;
    sched_d    = sched_q;
    next_d     = next_q;
    sw_d       = sw_q;
    ovf_d      = ovf_q;
    unique case (st_q)
      S_IDLE: begin
        if (take) begin
          next_d     = '0;
          sw_d       = 1'b0;
          ovf_d      = 1'b0;
          ins_pend_d = 1'b0;
          sched_d    = 1'b0;
          ins_id_d   = item_i.task_id;
          ins_rt_d   = item_i.runtime;
          ins_lvl_d  = item_i.level;
          unique case (item_i.kind)
            K_INSERT: begin
              if (item_i.task_id != cfg_i.idle_id) begin
                ovf_d      = q_full;
                ins_pend_d = !q_full;
              end
              st_d = S_INS;
            end
            K_SCHED: begin
              sched_d = 1'b1;
              c_lvl_d = c_lvl;
              if (cnt_q != '0) cnt_d = QW'(cnt_q - 1'b1);
              if (item_i.runtime >= c_rt) begin
                sw_d       = 1'b1;
                next_d     = c_id;
                ins_pend_d = item_i.is_running;
              end else begin
                next_d     = item_i.task_id;
                ins_pend_d = 1'b1;
                ins_id_d   = c_id;
                ins_rt_d   = c_rt;
                ins_lvl_d  = c_lvl;
              end
              st_d = S_INS;
            end
            K_TICK: begin
              if (slice_q != '0) slice_d = SLICE_W'(slice_q - 1'b1);
              st_d = S_OUT;
            end
            default: st_d = S_OUT;
          endcase
        end
      end
      S_INS: begin
        if (do_ins) cnt_d = QW'(cnt_q + 1'b1);
        st_d = sched_q ? S_RLD : S_OUT;
      end
      S_RLD: st_d = div_start ? S_DIV : S_OUT;
      S_DIV: begin
        if (div_done) begin
          slice_d = reload;
          st_d    = S_OUT;
        end
      end
      S_OUT: if (res_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      cnt_q   <= '0;
      slice_q <= SLICE_RESET;
    end else begin
      st_q    <= st_d;
      cnt_q   <= cnt_d;
      slice_q <= slice_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_pend_q <= ins_pend_d;
    ins_id_q   <= ins_id_d;
    ins_rt_q   <= ins_rt_d;
    ins_lvl_q  <= ins_lvl_d;
    c_lvl_q    <= c_lvl_d;
    sched_q    <= sched_d;
    next_q     <= next_d;
    sw_q       <= sw_d;
    ovf_q      <= ovf_d;
  end

  // queue storage: pop shifts toward the head, insert opens a gap
  always_ff @(posedge clk_i) begin
    if (do_pop) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        ent_id_q[k]  <= ent_id_q[k+1];
        ent_rt_q[k]  <= ent_rt_q[k+1];
        ent_lvl_q[k] <= ent_lvl_q[k+1];
      end
    end else if (do_ins) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        if (!lt[k]) begin
          if (k == 0 || lt[(k == 0) ? 0 : k-1]) begin
            ent_id_q[k]  <= ins_id_q;
            ent_rt_q[k]  <= ins_rt_q;
            ent_lvl_q[k] <= ins_lvl_q;
          end else begin
            ent_id_q[k]  <= ent_id_q[(k == 0) ? 0 : k-1];
            ent_rt_q[k]  <= ent_rt_q[(k == 0) ? 0 : k-1];
            ent_lvl_q[k] <= ent_lvl_q[(k == 0) ? 0 : k-1];
          end
        end
      end
    end
  end

  vrq_div #(.DIV_W(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg_i.base),
    .divisor_i  (DW'({1'b0, cnt_q} + 1'b1)),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign run_ext = 32'(cnt_q) + 32'd1;

  assign res_load_o       = (st_q == S_OUT) && res_ready_i;
  assign res_o.next_id    = next_q;
  assign res_o.switched   = sw_q;
  assign res_o.slice_left = slice_q;
  assign res_o.runnable   = run_ext[RUN_W-1:0];
  assign res_o.overflow   = ovf_q;
  assign q_count_o        = cnt_q;

endmodule

[rtl/vruntime_run_queue_scheduler.sv]
// Sequence: an insert passes the back end's S_INS and S_OUT states; a schedule passes S_INS,
// S_RLD and S_OUT, plus S_DIV for the 8-step divider when it reloads a zero slice; a tick goes
// straight to S_OUT. The back end takes a new word only in S_IDLE, after the last result is
// loaded; a two-word input queue and one output register decouple it.
// Reset: run queue empty, slice 4, registers at idle_id 0, idle_runtime 0,
// idle_level 0, base_slice 4. Queue entries hold no reset value.
module vruntime_run_queue_scheduler import vrq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  vrq_in_t     in_word_i,
  output logic        empty,
  input  logic        pop,
  output vrq_out_t    out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  `include "vruntime_run_queue_scheduler_assert.svh"

  localparam int unsigned QW = $clog2(QUEUE_DEPTH + 1);

  vrq_cfg_t      cfg_q;
  vrq_item_t     item;
  logic          item_valid, item_ready;
  logic          res_load, res_ready;
  vrq_out_t      res, res_q;
  logic          res_valid_q;
  logic [QW-1:0] q_count;
  logic [1:0]    reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_id  <= '0;
      cfg_q.idle_rt  <= '0;
      cfg_q.idle_lvl <= '0;
      cfg_q.base     <= BASE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IDLE_ID:  cfg_q.idle_id  <= pwdata[ID_W-1:0];
        REG_IDLE_RT:  cfg_q.idle_rt  <= pwdata[RT_W-1:0];
        REG_IDLE_LVL: cfg_q.idle_lvl <= pwdata[LVL_W-1:0];
        REG_BASE:     cfg_q.base     <= pwdata[BASE_W-1:0];
        default:      cfg_q.base     <= cfg_q.base;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IDLE_ID:  prdata = 64'(cfg_q.idle_id);
      REG_IDLE_RT:  prdata = 64'(cfg_q.idle_rt);
      REG_IDLE_LVL: prdata = 64'(cfg_q.idle_lvl);
      REG_BASE:     prdata = 64'(cfg_q.base);
      default:      prdata = '0;
    endcase
  end

  vrq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .word_i       (in_word_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  vrq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_ready_i  (res_ready),
    .res_load_o   (res_load),
    .res_o        (res),
    .q_count_o    (q_count)
  );

  // output register; a word may be refilled in the cycle it is popped
  assign res_ready = !res_valid_q || pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (pop) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) res_q <= res;
  end

  assign empty      = !res_valid_q;
  assign out_word_o = res_q;

  `VRQ_ASSERT(a_load_room, !res_load || empty || pop, "result loaded over a waiting word")
  `VRQ_ASSERT_NEXT(a_pop_drains, pop && !empty && !res_load, empty, "popped word still shown")
  `VRQ_ASSERT(a_count_range, q_count <= QW'(QUEUE_DEPTH), "run queue count past depth")

endmodule
